/* src/bgd_pkg.sv */
// Shared types and constants for the backlight glide dimmer.
package bgd_pkg;

	// Command codes carried by an input item.
	localparam logic [1:0] CMD_SET    = 2'd0;
	localparam logic [1:0] CMD_GLIDE  = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_SWITCH = 2'd3;

	// Level limits, in percent.
	localparam logic [6:0] LEVEL_MAX  = 7'd100;
	localparam logic [6:0] BRIGHT_MIN = 7'd10;

	// Minimum time between two glide steps, in milliseconds.
	localparam logic [31:0] STEP_INTERVAL_MS = 32'd16;

	// Duty = level*255/100; the divide by 100 is a multiply by 5243 / 2^19,
	// which is exact for every product up to 25500.
	localparam logic [12:0] DUTY_RECIP = 13'd5243;
	localparam int          DUTY_SHIFT = 19;

	// Configuration port widths and register indexes.
	localparam int         ADDR_W       = 3;
	localparam int         DATA_W       = 32;
	localparam logic [0:0] REG_USER_BRT = 1'b0;

	// One input item.
	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  level;
		logic [31:0] now_ms;
		logic        on;
	} item_t;

	// Dimmer state kept between items.
	typedef struct packed {
		logic [6:0]  cur;
		logic [6:0]  tgt;
		logic [31:0] last_ms;
	} state_t;

	// One result item.
	typedef struct packed {
		logic [6:0] level_now;
		logic [7:0] duty;
		logic       duty_written;
	} result_t;

endpackage

/* src/bgd_regs.sv */
// Configuration register file: the user brightness register behind an APB-style port.
module bgd_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bgd_pkg::ADDR_W-1:0] paddr,
	input  logic [bgd_pkg::DATA_W-1:0] pwdata,
	output logic [bgd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output logic [6:0]                 user_brightness
);
	import bgd_pkg::*;

	logic [6:0] ub_q;
	logic [6:0] wr_val;
	logic       wr_en;

	// Written values are held to the range 10..100.
	always_comb begin
		wr_val = pwdata[6:0];
		if (wr_val < BRIGHT_MIN) begin
			wr_val = BRIGHT_MIN;
		end else if (wr_val > LEVEL_MAX) begin
			wr_val = LEVEL_MAX;
		end
	end

	assign wr_en = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_USER_BRT);

	// Brightness register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ub_q <= LEVEL_MAX;
		end else if (wr_en) begin
			ub_q <= wr_val;
		end
	end

	// Reads return the register at its own address and zero elsewhere.
	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_USER_BRT) begin
			prdata = {{(DATA_W-7){1'b0}}, ub_q};
		end
	end

	assign pready          = 1'b1;
	assign user_brightness = ub_q;

endmodule

/* src/bgd_step.sv */
// Next-state and result logic for one command item.
module bgd_step (
	input  bgd_pkg::item_t   item,
	input  bgd_pkg::state_t  st,
	input  logic [6:0]       user_brightness,
	output bgd_pkg::state_t  st_next,
	output bgd_pkg::result_t res
);
	import bgd_pkg::*;

	logic [6:0]  req_lvl;
	logic [31:0] elapsed;
	logic        due;
	logic        rising;
	logic [6:0]  gap;
	logic [6:0]  step;
	logic        wrote;
	logic [14:0] scaled;
	logic [27:0] prod;

	// Requested level, clamped to 100.
	assign req_lvl = (item.level > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : item.level[6:0];

	// Wrapping time since the last step.
	assign elapsed = item.now_ms - st.last_ms;
	assign due     = (elapsed >= STEP_INTERVAL_MS);

	// Ease-out step: a quarter of the remaining distance, at least one.
	assign rising = (st.tgt > st.cur);
	assign gap    = rising ? (st.tgt - st.cur) : (st.cur - st.tgt);
	assign step   = (gap[6:2] == 5'd0) ? 7'd1 : {2'b00, gap[6:2]};

	// Command decode.
	always_comb begin
		st_next = st;
		wrote   = 1'b0;
		case (item.command)
			CMD_SET: begin
				st_next.cur = req_lvl;
				st_next.tgt = req_lvl;
				wrote       = 1'b1;
			end
			CMD_GLIDE: begin
				st_next.tgt = req_lvl;
			end
			CMD_TICK: begin
				if ((st.cur != st.tgt) && due) begin
					st_next.cur     = rising ? (st.cur + step) : (st.cur - step);
					st_next.last_ms = item.now_ms;
					wrote           = 1'b1;
				end
			end
			CMD_SWITCH: begin
				st_next.cur = item.on ? user_brightness : 7'd0;
				st_next.tgt = item.on ? user_brightness : 7'd0;
				wrote       = 1'b1;
			end
			default: begin
				st_next = st;
			end
		endcase
	end

	// Duty: level*255 by shift and subtract, then divide by 100 via reciprocal.
	assign scaled = {st_next.cur, 8'b0} - {8'b0, st_next.cur};
	assign prod   = 28'(scaled) * 28'(DUTY_RECIP);

	assign res.level_now    = st_next.cur;
	assign res.duty         = prod[DUTY_SHIFT+7:DUTY_SHIFT];
	assign res.duty_written = wrote;

endmodule

/* src/backlight_glide_dimmer_core.sv */
// Top level of the backlight glide dimmer: input register, step logic, result register.
//
//   channel   handshake           payload
//   in        in_valid/in_ready   command, level, now_ms, on
//   out       out_valid/out_ready level_now, duty, duty_written
//   cfg       psel/penable/pready paddr, pwrite, pwdata, prdata
//
// An item passes from the input register into the result register, where its
// result is presented until taken; one item per cycle is sustained while
// out_ready holds. The dimmer state updates as an item moves from the input
// register into the result register, so the next item sees it at once.
// Reset clears the state to level 0, target 0, step time 0 and brightness 100.
// A stalled result holds the input register; new items are taken again as soon
// as the result register drains.
module backlight_glide_dimmer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bgd_pkg::ADDR_W-1:0] paddr,
	input  logic [bgd_pkg::DATA_W-1:0] pwdata,
	output logic [bgd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic [7:0]                 level,
	input  logic [31:0]                now_ms,
	input  logic                       on,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [6:0]                 level_now,
	output logic [7:0]                 duty,
	output logic                       duty_written
);
	import bgd_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       advance;
	logic       out_valid_q;
	result_t    res_q;
	state_t     st_q;
	state_t     st_next;
	result_t    res_next;
	logic [6:0] user_brightness;

	// Configuration registers.
	bgd_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.user_brightness (user_brightness)
	);

	// Step logic between the input register and the result register.
	bgd_step u_step (
		.item            (item_s1),
		.st              (st_q),
		.user_brightness (user_brightness),
		.st_next         (st_next),
		.res             (res_next)
	);

	// The input item moves on when the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{command: command, level: level, now_ms: now_ms, on: on};
		end
	end

	// Dimmer state, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign level_now    = res_q.level_now;
	assign duty         = res_q.duty;
	assign duty_written = res_q.duty_written;

	// The level and target never leave the percent range.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.cur <= LEVEL_MAX) && (st_q.tgt <= LEVEL_MAX))
		else $error("dimmer level or target above 100");

	// The brightness register stays inside 10..100.
	a_brt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(user_brightness >= BRIGHT_MIN) && (user_brightness <= LEVEL_MAX))
		else $error("user brightness out of range");

	// A pending result reports the level the state now holds.
	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.level_now == st_q.cur))
		else $error("result level differs from current state");

	// A step that did not write the duty leaves the step time alone.
	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !res_next.duty_written) |=> $stable(st_q.last_ms))
		else $error("step time changed without a duty write");

endmodule
